@@ rtl/bdda_pkg.sv @@
// Shared types, constants and calendar helper functions of the business-day date adder.
package bdda_pkg;

    // Field widths of one input item and one result item.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 15;
    localparam int WDAY_W  = 3;
    localparam int MASK_W  = 7;

    // Packed stream widths, filled up to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // Calendar limits and register reset values.
    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
    localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;
    localparam logic [MASK_W-1:0]  MASK_ALL   = 7'h7F;
    localparam logic [WDAY_W-1:0]  LAST_WDAY  = 3'd6;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
    localparam logic [MONTH_W-1:0] MARCH      = 4'd3;
    localparam logic [6:0]         LAST_R100  = 7'd99;

    // Reciprocal constants: floor(y/100) = (y*5243) >> 19 for y < 16384,
    // floor(s/7) = (s*18725) >> 17 for s < 32768.
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam logic [14:0] RECIP_7   = 15'd18725;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch the input item
        logic calc_q;    // divide the years by 100
        logic calc_rem;  // remainder by 100 and weekday sum
        logic calc_mod;  // divide the sum by 7 and check the date
        logic calc_wd;   // weekday of the start date
        logic step;      // advance the walk by one calendar day
        logic out_load;  // move the final date into the output register
    } t_cmd;

    // Status bundle from the datapath to the controller.
    typedef struct packed {
        logic done;      // the walk has reached its result
    } t_stat;

    // Length of a month; zero for codes that are no month.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Month term (31*m)/12 of the weekday formula, with m = month + 12*a - 2.
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] ofs;
        unique case (month)
            4'd1:    ofs = 5'd28;
            4'd2:    ofs = 5'd31;
            4'd3:    ofs = 5'd2;
            4'd4:    ofs = 5'd5;
            4'd5:    ofs = 5'd7;
            4'd6:    ofs = 5'd10;
            4'd7:    ofs = 5'd12;
            4'd8:    ofs = 5'd15;
            4'd9:    ofs = 5'd18;
            4'd10:   ofs = 5'd20;
            4'd11:   ofs = 5'd23;
            4'd12:   ofs = 5'd25;
            default: ofs = 5'd0;
        endcase
        return ofs;
    endfunction

endpackage

@@ rtl/bdda_ctrl.sv @@
// Controller state machine: sequences the weekday setup, the day walk and the output register.
module bdda_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bdda_pkg::t_cmd  o_cmd,
    input  bdda_pkg::t_stat i_stat
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_Q100 = 6'b000010,
        S_REM  = 6'b000100,
        S_MOD  = 6'b001000,
        S_WDAY = 6'b010000,
        S_WALK = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // The output register can take a new result when empty or being emptied.
    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_Q100;
                end
            end
            S_Q100: begin
                o_cmd.calc_q = 1'b1;
                n_state      = S_REM;
            end
            S_REM: begin
                o_cmd.calc_rem = 1'b1;
                n_state        = S_MOD;
            end
            S_MOD: begin
                o_cmd.calc_mod = 1'b1;
                n_state        = S_WDAY;
            end
            S_WDAY: begin
                o_cmd.calc_wd = 1'b1;
                n_state       = S_WALK;
            end
            S_WALK: begin
                if (!i_stat.done) begin
                    o_cmd.step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid flag follows loads and consumer handshakes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/bdda_dpath.sv @@
// Datapath: date checks, weekday arithmetic, day-by-day calendar walk and result register.
module bdda_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [bdda_pkg::MASK_W-1:0]         i_cfg_wr_data,
    input  logic [bdda_pkg::DAY_W-1:0]          i_start_day,
    input  logic [bdda_pkg::MONTH_W-1:0]        i_start_month,
    input  logic [bdda_pkg::YEAR_W-1:0]         i_start_year,
    input  logic [bdda_pkg::COUNT_W-1:0]        i_vacation_days,
    input  bdda_pkg::t_cmd                      i_cmd,
    output bdda_pkg::t_stat                     o_stat,
    output logic [bdda_pkg::DAY_W-1:0]          o_return_day,
    output logic [bdda_pkg::MONTH_W-1:0]        o_return_month,
    output logic [bdda_pkg::YEAR_W-1:0]         o_return_year,
    output logic [bdda_pkg::WDAY_W-1:0]         o_return_weekday,
    output logic                                o_overflow
);

    // Weekend mask register.
    logic [bdda_pkg::MASK_W-1:0]  r_mask;

    // Current walk position.
    logic [bdda_pkg::DAY_W-1:0]   r_day;
    logic [bdda_pkg::MONTH_W-1:0] r_month;
    logic [bdda_pkg::YEAR_W-1:0]  r_year;
    logic [bdda_pkg::COUNT_W-1:0] r_left;
    logic [bdda_pkg::WDAY_W-1:0]  r_wd;
    logic [6:0]                   r_ymod100;  // year mod 100
    logic [1:0]                   r_c4;       // (year / 100) mod 4
    logic                         r_bad;      // start date rejected or no business day

    // Setup intermediates.
    logic [bdda_pkg::YEAR_W-1:0]  r_yp;       // year shifted for January and February
    logic [bdda_pkg::DAY_W-1:0]   r_tab;
    logic [7:0]                   r_q100y;
    logic [7:0]                   r_q100p;
    logic [6:0]                   r_r100y;
    logic [14:0]                  r_sum;
    logic [12:0]                  r_q7;

    // Result register.
    logic [bdda_pkg::DAY_W-1:0]   r_o_day;
    logic [bdda_pkg::MONTH_W-1:0] r_o_month;
    logic [bdda_pkg::YEAR_W-1:0]  r_o_year;
    logic [bdda_pkg::WDAY_W-1:0]  r_o_wd;
    logic                         r_o_ovf;

    logic                         w_early;
    logic [26:0]                  w_prod_y;
    logic [26:0]                  w_prod_p;
    logic [14:0]                  w_hund;
    logic [14:0]                  w_r100;
    logic [14:0]                  w_sum;
    logic [31:0]                  w_prod7;
    logic [14:0]                  w_sev;
    logic [14:0]                  w_wdiff;
    logic                         w_leap_start;
    logic                         w_invalid;
    logic                         w_leap_cur;
    logic [bdda_pkg::DAY_W-1:0]   w_dim;
    logic                         w_wk;
    logic                         w_finish;
    logic                         w_month_end;
    logic                         w_year_end;
    logic                         w_step_ovf;
    logic                         w_ovf_res;

    // Setup arithmetic; each reciprocal multiplication is registered before its quotient is used.
    assign w_early  = (i_start_month < bdda_pkg::MARCH);
    assign w_prod_y = {13'd0, r_year} * {14'd0, bdda_pkg::RECIP_100};
    assign w_prod_p = {13'd0, r_yp} * {14'd0, bdda_pkg::RECIP_100};
    assign w_hund   = {7'd0, r_q100y} * 15'd100;
    assign w_r100   = {1'b0, r_year} - w_hund;
    assign w_sum    = {10'd0, r_day} + {1'b0, r_yp} + {3'd0, r_yp[13:2]}
                    - {7'd0, r_q100p} + {9'd0, r_q100p[7:2]} + {10'd0, r_tab};
    assign w_prod7  = {17'd0, r_sum} * {17'd0, bdda_pkg::RECIP_7};
    assign w_sev    = {2'd0, r_q7} * 15'd7;
    assign w_wdiff  = r_sum - w_sev;

    // Start date check, using the leap rule on the start year.
    assign w_leap_start = ((r_r100y != 7'd0) && (r_year[1:0] == 2'd0)) ||
                          ((r_r100y == 7'd0) && (r_q100y[1:0] == 2'd0));
    assign w_invalid = (r_day == '0) || (r_month == '0) || (r_month > bdda_pkg::DECEMBER) ||
                       (r_year == '0) || (r_year > bdda_pkg::MAX_YEAR) ||
                       (r_day > bdda_pkg::month_days(r_month, w_leap_start)) ||
                       (r_mask == bdda_pkg::MASK_ALL);

    // Walk step: leap rule kept current through the year counters.
    assign w_leap_cur  = ((r_ymod100 != 7'd0) && (r_year[1:0] == 2'd0)) ||
                         ((r_ymod100 == 7'd0) && (r_c4 == 2'd0));
    assign w_dim       = bdda_pkg::month_days(r_month, w_leap_cur);
    assign w_wk        = r_mask[r_wd];
    assign w_finish    = (r_left == '0) && !w_wk;
    assign w_month_end = (r_day >= w_dim);
    assign w_year_end  = w_month_end && (r_month >= bdda_pkg::DECEMBER);
    assign w_step_ovf  = w_year_end && (r_year >= bdda_pkg::MAX_YEAR);
    assign w_ovf_res   = r_bad || (!w_finish && w_step_ovf);

    assign o_stat.done = r_bad || w_finish || w_step_ovf;

    // Weekend mask register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= bdda_pkg::MASK_RESET;
        end else if (i_cfg_wr_en) begin
            r_mask <= i_cfg_wr_data;
        end
    end

    // Setup registers and the walk position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= i_start_day;
            r_month <= i_start_month;
            r_year  <= i_start_year;
            r_left  <= i_vacation_days;
            r_yp    <= i_start_year - {13'd0, w_early};
            r_tab   <= bdda_pkg::month_offset(i_start_month);
        end
        if (i_cmd.calc_q) begin
            r_q100y <= w_prod_y[26:19];
            r_q100p <= w_prod_p[26:19];
        end
        if (i_cmd.calc_rem) begin
            r_r100y <= w_r100[6:0];
            r_sum   <= w_sum;
        end
        if (i_cmd.calc_mod) begin
            r_q7      <= w_prod7[29:17];
            r_bad     <= w_invalid;
            r_ymod100 <= r_r100y;
            r_c4      <= r_q100y[1:0];
        end
        if (i_cmd.calc_wd) begin
            r_wd <= w_wdiff[2:0];
        end
        if (i_cmd.step) begin
            // Business days use up one count.
            if (!w_wk) begin
                r_left <= r_left - 1'b1;
            end
            r_wd <= (r_wd == bdda_pkg::LAST_WDAY) ? '0 : r_wd + 1'b1;
            if (!w_month_end) begin
                r_day <= r_day + 1'b1;
            end else begin
                r_day <= 5'd1;
                if (!w_year_end) begin
                    r_month <= r_month + 1'b1;
                end else begin
                    r_month   <= 4'd1;
                    r_year    <= r_year + 1'b1;
                    r_ymod100 <= (r_ymod100 == bdda_pkg::LAST_R100) ? '0 : r_ymod100 + 1'b1;
                    if (r_ymod100 == bdda_pkg::LAST_R100) begin
                        r_c4 <= r_c4 + 1'b1;
                    end
                end
            end
        end
    end

    // Result register; an overflow clears the date fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_ovf   <= w_ovf_res;
            r_o_day   <= w_ovf_res ? '0 : r_day;
            r_o_month <= w_ovf_res ? '0 : r_month;
            r_o_year  <= w_ovf_res ? '0 : r_year;
            r_o_wd    <= w_ovf_res ? '0 : r_wd;
        end
    end

    assign o_return_day     = r_o_day;
    assign o_return_month   = r_o_month;
    assign o_return_year    = r_o_year;
    assign o_return_weekday = r_o_wd;
    assign o_overflow       = r_o_ovf;

endmodule

@@ rtl/business_day_date_adder.sv @@
// Top level of the business-day date adder: stream ports, controller and datapath.
//
// One item carries a start date and a count of business days; the block answers with the
// first business day after the count is used up (the first business day on or after the
// start for a count of zero), its weekday (0 Sunday), and an overflow flag when the walk
// would pass 31 December 9999 or the start date is rejected. After acceptance, the setup
// states S_Q100, S_REM, S_MOD and S_WDAY work out the weekday of the start date, the walk
// advances one calendar day per cycle, and once the walk is done the result is moved into
// the output register. The block takes the next item only after that move; while an
// earlier result still waits in the output register, the finished walk holds and the
// input stays closed. The weekend mask (bit d marks weekday d as weekend, reset Friday
// and Saturday) is to be written through i_cfg_wr_en only while the block is idle; the
// block itself does not enforce this.
module business_day_date_adder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bdda_pkg::MASK_W-1:0]        i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], vacation_days[37:23], zero[39:38]
    input  logic [bdda_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // return_day[4:0], return_month[8:5], return_year[22:9], return_weekday[25:23],
    // zero[31:26]
    output logic [bdda_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // overflow[0]
    output logic                               m_axis_tuser
);

    bdda_pkg::t_cmd                 w_cmd;
    bdda_pkg::t_stat                w_stat;
    logic [bdda_pkg::DAY_W-1:0]     w_ret_day;
    logic [bdda_pkg::MONTH_W-1:0]   w_ret_month;
    logic [bdda_pkg::YEAR_W-1:0]    w_ret_year;
    logic [bdda_pkg::WDAY_W-1:0]    w_ret_wd;

    bdda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    bdda_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_start_day      (s_axis_tdata[4:0]),
        .i_start_month    (s_axis_tdata[8:5]),
        .i_start_year     (s_axis_tdata[22:9]),
        .i_vacation_days  (s_axis_tdata[37:23]),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_return_day     (w_ret_day),
        .o_return_month   (w_ret_month),
        .o_return_year    (w_ret_year),
        .o_return_weekday (w_ret_wd),
        .o_overflow       (m_axis_tuser)
    );

    // Pack the result item.
    assign m_axis_tdata = {6'd0, w_ret_wd, w_ret_year, w_ret_month, w_ret_day};

endmodule

@@ rtl/bdda_checker.sv @@
// Port-level checker of the business-day date adder and its bind to the top level.
module bdda_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [bdda_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input logic                            i_m_tuser
);

    // A pending result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result item dropped before it was taken");

    // The block works on one item at a time: accepting an item closes the input.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input still open while an item is at work");

    // An overflow result carries an all-zero date.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tdata == '0)
        else $error("overflow result with nonzero date fields");

    // A good result has a nonzero day, a month from 1 to 12, a nonzero year and a weekday below 7.
    a_good_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |->
            (i_m_tdata[4:0] != 5'd0) && (i_m_tdata[8:5] != 4'd0) &&
            (i_m_tdata[8:5] <= 4'd12) && (i_m_tdata[22:9] != 14'd0) &&
            (i_m_tdata[25:23] != 3'd7))
        else $error("result date out of range");

endmodule

bind business_day_date_adder bdda_checker u_bdda_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

@@ tb/sv/business_day_date_adder_tb.sv @@
// Self-checking testbench for the business-day date adder: stream stimulus and return-date checks.
module business_day_date_adder_tb;
    import bdda_pkg::*;

    localparam int QUIET_LIMIT   = 200000;
    localparam int TAIL_CYCLES   = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 116;

    // One request, packed so that start_day lands in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] vacation_days;
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
    } t_request;

    // One return date with its overflow flag on top.
    typedef struct packed {
        logic               overflow;
        logic [WDAY_W-1:0]  weekday;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_return;

    // Walks the calendar for each accepted request and checks the return dates in order.
    class return_date_book;
        logic [MASK_W-1:0] weekend_mask;
        int unsigned       cur_day, cur_month, cur_year, cur_weekday, days_left;
        t_return           pending_returns[$];
        int                errors, n_requests, n_returns, n_overflows, longest_walk;

        function new();
            weekend_mask = MASK_RESET;
            cur_day      = 1;
            cur_month    = 1;
            cur_year     = 1;
            cur_weekday  = 0;
            days_left    = 0;
            errors       = 0;
            n_requests   = 0;
            n_returns    = 0;
            n_overflows  = 0;
            longest_walk = 0;
        endfunction

        function int unsigned month_length(input int unsigned m, input int unsigned y);
            bit leap;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // Weekday with 0 as Sunday; January and February count as months of the prior year.
        function int unsigned weekday_of(input int unsigned d, input int unsigned mo,
                                         input int unsigned yr);
            int unsigned a, y, m;
            a = (14 - mo) / 12;
            y = yr - a;
            m = mo + 12 * a - 2;
            return (d + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
        endfunction

        // Steps one calendar day; returns 0 when the walk would leave year 9999.
        function bit advance_day();
            cur_weekday = (cur_weekday + 1) % 7;
            if (cur_day >= month_length(cur_month, cur_year)) begin
                cur_day = 1;
                if (cur_month >= DECEMBER) begin
                    cur_month = 1;
                    if (cur_year >= MAX_YEAR)
                        return 0;
                    cur_year++;
                end else begin
                    cur_month++;
                end
            end else begin
                cur_day++;
            end
            return 1;
        endfunction

        function void note_request(input t_request req);
            t_return     ret;
            bit          ovf;
            bit          off_day;
            int          walked;
            int unsigned d, m, y;
            d      = req.start_day;
            m      = req.start_month;
            y      = req.start_year;
            ovf    = 0;
            walked = 0;
            n_requests++;
            if (d == 0 || m < 1 || m > 12 || y == 0 || y > MAX_YEAR ||
                d > month_length(m, y) || weekend_mask == MASK_ALL) begin
                ovf = 1;
            end else begin
                cur_day     = d;
                cur_month   = m;
                cur_year    = y;
                cur_weekday = weekday_of(d, m, y);
                days_left   = req.vacation_days;
                // Business days use up the count; weekend days are stepped over.
                forever begin
                    off_day = weekend_mask[cur_weekday];
                    if (days_left == 0 && !off_day)
                        break;
                    if (!off_day)
                        days_left--;
                    if (!advance_day()) begin
                        ovf = 1;
                        break;
                    end
                    walked++;
                end
            end
            if (walked > longest_walk)
                longest_walk = walked;
            if (ovf) begin
                ret          = '0;
                ret.overflow = 1'b1;
            end else begin
                ret.overflow = 1'b0;
                ret.weekday  = cur_weekday[WDAY_W-1:0];
                ret.year     = cur_year[YEAR_W-1:0];
                ret.month    = cur_month[MONTH_W-1:0];
                ret.day      = cur_day[DAY_W-1:0];
            end
            pending_returns.push_back(ret);
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] data, input logic ovf);
            t_return got, want;
            got = {ovf, data[25:0]};
            n_returns++;
            if (got.overflow)
                n_overflows++;
            if (pending_returns.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Unexpected result: %0d-%0d-%0d weekday %0d overflow %0d",
                             got.year, got.month, got.day, got.weekday, got.overflow);
                return;
            end
            want = pending_returns.pop_front();
            if (got.day !== want.day || got.month !== want.month || got.year !== want.year ||
                got.weekday !== want.weekday || got.overflow !== want.overflow) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("Mismatch on result %0d: expected %0d-%0d-%0d weekday %0d overflow %0d",
                             n_returns, want.year, want.month, want.day, want.weekday,
                             want.overflow);
                    $display("    got %0d-%0d-%0d weekday %0d overflow %0d",
                             got.year, got.month, got.day, got.weekday, got.overflow);
                end
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [MASK_W-1:0]     i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    return_date_book book;
    bit              receiver_stalls = 1'b1;
    logic [15:0]     stall_pattern   = 16'hA5C3;
    int              quiet_cycles    = 0;
    int              masks_used      = 1;

    business_day_date_adder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // The receiver follows a rotating stall pattern that is reloaded now and then.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0)
            stall_pattern <= 16'($urandom) | 16'h0101;
        else
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        m_axis_tready <= !receiver_stalls || stall_pattern[0];
    end

    // Every accepted result is checked against the oldest pending return date.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata, m_axis_tuser);
    end

    // The run ends as failed if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL business_day_date_adder");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_request make_request(input int d, input int m, input int y, input int v);
        t_request req;
        req.start_day     = d[DAY_W-1:0];
        req.start_month   = m[MONTH_W-1:0];
        req.start_year    = y[YEAR_W-1:0];
        req.vacation_days = v[COUNT_W-1:0];
        return req;
    endfunction

    // Mostly valid dates with short counts; a few invalid dates, years near the end, long walks.
    function automatic t_request random_request(input logic [MASK_W-1:0] mask);
        t_request    req;
        int unsigned pick, len, busy;
        busy = $countones(mask);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            req.start_year = 14'($urandom_range(1, MAX_YEAR));
        else if (pick < 70)
            req.start_year = 14'($urandom_range(9950, MAX_YEAR));
        else if (pick < 80)
            req.start_year = 14'($urandom_range(1, 4));
        else if (pick < 92)
            req.start_year = 14'($urandom_range(1600, 2400));
        else
            req.start_year = 14'($urandom_range(0, 16383));
        if ($urandom_range(0, 9) == 0)
            req.start_month = 4'($urandom_range(0, 15));
        else
            req.start_month = 4'($urandom_range(1, 12));
        len = book.month_length(req.start_month, req.start_year);
        if (len == 0 || $urandom_range(0, 7) == 0)
            req.start_day = 5'($urandom_range(0, 31));
        else
            req.start_day = 5'($urandom_range(1, len));
        pick = $urandom_range(0, 199);
        if (pick == 0 && busy <= 2)
            req.vacation_days = 15'($urandom_range(0, 32767));
        else if (pick < 20)
            req.vacation_days = 15'($urandom_range(0, (busy >= 4) ? 300 : 2000));
        else if (pick < 70)
            req.vacation_days = 15'($urandom_range(0, 200));
        else if (pick < 80)
            req.vacation_days = '0;
        else
            req.vacation_days = 15'($urandom_range(1, 30));
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_request(input t_request req);
        s_axis_tdata  <= {2'b00, req};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic drain_returns();
        while (book.pending_returns.size() != 0)
            @(negedge i_clk);
    endtask

    // The mask is only changed once the block has handed back every result.
    task automatic write_weekend_mask(input logic [MASK_W-1:0] mask);
        s_axis_tvalid <= 1'b0;
        drain_returns();
        repeat (8) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mask;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        book.weekend_mask = mask;
        masks_used++;
    endtask

    task automatic run_random_phase(input int n_items, input bit bursty, input bit drain_midway);
        int burst_left;
        int k;
        burst_left = $urandom_range(1, 8);
        for (k = 0; k < n_items; k++) begin
            send_request(random_request(book.weekend_mask));
            burst_left--;
            if (drain_midway && k == n_items / 2) begin
                // Hold the sender until every outstanding result is back.
                s_axis_tvalid <= 1'b0;
                drain_returns();
            end else if (bursty && burst_left <= 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end
        end
    endtask

    initial begin
        int                ph;
        logic [MASK_W-1:0] mask_pick;
        book = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items under the reset weekend of Friday and Saturday.
        send_request(make_request(1, 1, 1, 0));
        send_request(make_request(31, 12, 9999, 0));
        send_request(make_request(31, 12, 9999, 1));
        send_request(make_request(1, 1, 1, 32767));
        send_request(make_request(29, 2, 2000, 5));
        send_request(make_request(29, 2, 1900, 5));
        send_request(make_request(29, 2, 2024, 20));
        send_request(make_request(28, 2, 2023, 1));
        send_request(make_request(0, 5, 2020, 3));
        send_request(make_request(10, 0, 2020, 3));
        send_request(make_request(10, 13, 2020, 3));
        send_request(make_request(31, 15, 16383, 32767));
        send_request(make_request(15, 6, 0, 2));
        send_request(make_request(1, 1, 10000, 2));
        send_request(make_request(31, 4, 2021, 2));
        send_request(make_request(31, 12, 2021, 30));
        send_request(make_request(1, 3, 2024, 0));
        send_request(make_request(1, 1, 9990, 32767));

        // No weekend at all, then every day a weekend, then only Sunday open.
        write_weekend_mask(7'd0);
        send_request(make_request(1, 1, 2000, 0));
        send_request(make_request(5, 5, 5, 32767));
        write_weekend_mask(MASK_ALL);
        send_request(make_request(1, 1, 2000, 3));
        send_request(make_request(0, 0, 0, 0));
        write_weekend_mask(7'd126);
        send_request(make_request(1, 3, 2024, 0));
        send_request(make_request(1, 1, 2024, 10));

        // Random phases, each under its own weekend and its own idling.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            mask_pick = (ph == 0) ? 7'd65 : 7'($urandom_range(0, 126));
            write_weekend_mask(mask_pick);
            receiver_stalls = (ph % 4 != 3);
            run_random_phase(PHASE_ITEMS, ph % 3 != 2, ph == 1);
        end

        s_axis_tvalid <= 1'b0;
        drain_returns();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items under %0d weekend masks: %0d overflow results,",
                 book.n_requests, masks_used, book.n_overflows);
        $display("longest walk %0d calendar days, %0d results checked.",
                 book.longest_walk, book.n_returns);
        if (book.errors == 0 && book.pending_returns.size() == 0) begin
            $display("PASS business_day_date_adder");
        end else begin
            $display("%0d bad results, %0d results never arrived.",
                     book.errors, book.pending_returns.size());
            $display("FAIL business_day_date_adder");
        end
        $finish;
    end

endmodule
